/* rtl/rti_pkg.sv */
// Shared types and constants for the ray/triangle intersection unit.
`default_nettype none
package rti_pkg;

    localparam int DATA_W    = 32;
    localparam int TOL_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd6;

    localparam logic signed [DATA_W-1:0] DIR_X_RST = 32'sd65536;
    localparam logic [TOL_W-1:0]         TOL_RST   = 17'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] v0_x;
        logic signed [DATA_W-1:0] v0_y;
        logic signed [DATA_W-1:0] v0_z;
        logic signed [DATA_W-1:0] v1_x;
        logic signed [DATA_W-1:0] v1_y;
        logic signed [DATA_W-1:0] v1_z;
        logic signed [DATA_W-1:0] v2_x;
        logic signed [DATA_W-1:0] v2_y;
        logic signed [DATA_W-1:0] v2_z;
    } t_tri_item;

    typedef struct packed {
        logic hit;
    } t_res_item;

endpackage
`default_nettype wire

/* rtl/rti_in_if.sv */
// Triangle input channel.
`default_nettype none
interface rti_in_if;
    logic                 valid;
    logic                 ready;
    rti_pkg::t_tri_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/rti_out_if.sv */
// Hit result channel.
`default_nettype none
interface rti_out_if;
    logic                 valid;
    logic                 ready;
    rti_pkg::t_res_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ray_triangle_intersect_unit.sv */
// Ray/triangle intersection unit: Moller-Trumbore test, pipelined.
// Usage:
//   Load origin, direction and tolerance through the write port while idle.
//   Triangles enter on i_tri (valid/ready); one hit flag per triangle
//   leaves on o_res in arrival order.
//   The path from acceptance to o_res.valid runs through five arithmetic
//   stages (edges, cross products, cross sums, dot products, dot sums),
//   one divider setup stage, 32 restoring divider stages (one quotient bit
//   each, three quotients side by side), a quotient saturation stage and
//   the compare/output register.
//   Throughput is one triangle per cycle while o_res is not stalled; the
//   three divider chains are the longest part of the pipe.
//   The whole pipe advances together; i_tri.ready is low only while the
//   output register holds a result that is not taken, so a stall freezes
//   every stage and nothing is dropped or repeated.
//   Reset clears all valid bits and loads the register defaults: origin 0,
//   direction (1.0, 0, 0), tolerance 1 LSB.
`default_nettype none
module ray_triangle_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rti_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rti_pkg::DATA_W-1:0]      i_cfg_data,
    rti_in_if.sink                               i_tri,
    rti_out_if.source                            o_res
);

    localparam int W   = rti_pkg::DATA_W;
    localparam int TW  = rti_pkg::TOL_W;
    localparam int PW  = 2 * W;
    localparam int SW  = PW - FRAC_BITS + 2;
    localparam int NDV = W;
    localparam int CW  = W + 2;
    localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    // ---------------- configuration ----------------
    logic signed [W-1:0] r_org [3];
    logic signed [W-1:0] r_dir [3];
    logic [TW-1:0]       r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= rti_pkg::DIR_X_RST;
            r_dir[1] <= '0;
            r_dir[2] <= '0;
            r_tol    <= rti_pkg::TOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rti_pkg::CFG_ORIGIN_X:  r_org[0] <= i_cfg_data;
                rti_pkg::CFG_ORIGIN_Y:  r_org[1] <= i_cfg_data;
                rti_pkg::CFG_ORIGIN_Z:  r_org[2] <= i_cfg_data;
                rti_pkg::CFG_DIR_X:     r_dir[0] <= i_cfg_data;
                rti_pkg::CFG_DIR_Y:     r_dir[1] <= i_cfg_data;
                rti_pkg::CFG_DIR_Z:     r_dir[2] <= i_cfg_data;
                rti_pkg::CFG_TOLERANCE: r_tol    <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- helpers ----------------
    function automatic logic signed [W-1:0] sat_d(input logic signed [W:0] x);
        if (x[W] == x[W-1]) return x[W-1:0];
        return x[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic signed [W-1:0] sat_s(input logic signed [SW-1:0] x);
        if ((&x[SW-1:W-1]) || !(|x[SW-1:W-1])) return x[W-1:0];
        return x[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    // floor(p / 2^FRAC_BITS), fits in SW bits
    function automatic logic signed [SW-1:0] fsh(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] sh;
        sh = p >>> FRAC_BITS;
        return SW'(sh);
    endfunction

    function automatic logic signed [PW-1:0] mul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [PW-1:0] ax;
        logic signed [PW-1:0] bx;
        ax = PW'(a);
        bx = PW'(b);
        return ax * bx;
    endfunction

    function automatic logic [W-1:0] absv(input logic signed [W-1:0] x);
        return x[W-1] ? W'(-x) : W'(x);
    endfunction

    // ---------------- pipeline control ----------------
    logic r_out_vld;
    logic r_out_hit;
    logic en;

    assign en          = !r_out_vld || o_res.ready;
    assign i_tri.ready = en;

    // ---------------- stage 1: e1, e2, s ----------------
    logic signed [W-1:0] va [3];
    logic signed [W-1:0] vb [3];
    logic signed [W-1:0] vc [3];
    logic                r_v1;
    logic signed [W-1:0] r_e1_1 [3];
    logic signed [W-1:0] r_e2_1 [3];
    logic signed [W-1:0] r_s_1  [3];

    always_comb begin
        va[0] = i_tri.data.v0_x; va[1] = i_tri.data.v0_y; va[2] = i_tri.data.v0_z;
        vb[0] = i_tri.data.v1_x; vb[1] = i_tri.data.v1_y; vb[2] = i_tri.data.v1_z;
        vc[0] = i_tri.data.v2_x; vc[1] = i_tri.data.v2_y; vc[2] = i_tri.data.v2_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1_1[i] <= sat_d((W+1)'(vb[i]) - (W+1)'(va[i]));
                r_e2_1[i] <= sat_d((W+1)'(vc[i]) - (W+1)'(va[i]));
                r_s_1[i]  <= sat_d((W+1)'(r_org[i]) - (W+1)'(va[i]));
            end
        end
    end

    // ---------------- stage 2: cross-product terms ----------------
    logic                 r_v2;
    logic signed [PW-1:0] r_pp [6];
    logic signed [PW-1:0] r_pq [6];
    logic signed [W-1:0]  r_e1_2 [3];
    logic signed [W-1:0]  r_e2_2 [3];
    logic signed [W-1:0]  r_s_2  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_pp[2*i]   <= mul(r_dir[(i+1)%3], r_e2_1[(i+2)%3]);
                r_pp[2*i+1] <= mul(r_dir[(i+2)%3], r_e2_1[(i+1)%3]);
                r_pq[2*i]   <= mul(r_s_1[(i+1)%3], r_e1_1[(i+2)%3]);
                r_pq[2*i+1] <= mul(r_s_1[(i+2)%3], r_e1_1[(i+1)%3]);
            end
            r_e1_2 <= r_e1_1;
            r_e2_2 <= r_e2_1;
            r_s_2  <= r_s_1;
        end
    end

    // ---------------- stage 3: p = dir x e2, q = s x e1 ----------------
    logic                r_v3;
    logic signed [W-1:0] r_p [3];
    logic signed [W-1:0] r_q [3];
    logic signed [W-1:0] r_e1_3 [3];
    logic signed [W-1:0] r_e2_3 [3];
    logic signed [W-1:0] r_s_3  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= sat_s(fsh(r_pp[2*i]) - fsh(r_pp[2*i+1]));
                r_q[i] <= sat_s(fsh(r_pq[2*i]) - fsh(r_pq[2*i+1]));
            end
            r_e1_3 <= r_e1_2;
            r_e2_3 <= r_e2_2;
            r_s_3  <= r_s_2;
        end
    end

    // ---------------- stage 4: dot-product terms ----------------
    // row 0: e1.p (det), 1: s.p (u), 2: dir.q (v), 3: e2.q (t)
    logic                 r_v4;
    logic signed [PW-1:0] r_m [4][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_m[0][i] <= mul(r_e1_3[i], r_p[i]);
                r_m[1][i] <= mul(r_s_3[i], r_p[i]);
                r_m[2][i] <= mul(r_dir[i], r_q[i]);
                r_m[3][i] <= mul(r_e2_3[i], r_q[i]);
            end
        end
    end

    // ---------------- stage 5: dot sums ----------------
    logic                r_v5;
    logic signed [W-1:0] r_dot [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r_dot[j] <= sat_s(fsh(r_m[j][0]) + fsh(r_m[j][1]) + fsh(r_m[j][2]));
            end
        end
    end

    // ---------------- divider chain ----------------
    // index 0 is the setup stage; each later stage adds one quotient bit.
    logic            r_dvld [NDV+1];
    logic [W-1:0]    r_dabs [NDV+1];
    logic            r_magok[NDV+1];
    logic [W-1:0]    r_rem  [NDV+1][3];
    logic [W-1:0]    r_lo   [NDV+1][3];
    logic            r_ovf  [NDV+1][3];
    logic            r_neg  [NDV+1][3];
    logic            r_nz   [NDV+1][3];

    logic [W-1:0]    nabs [3];
    logic [PW-1:0]   nwide [3];
    logic [W-1:0]    dabs;

    always_comb begin
        dabs = absv(r_dot[0]);
        for (int j = 0; j < 3; j++) begin
            nabs[j]  = absv(r_dot[j+1]);
            nwide[j] = PW'(nabs[j]) << FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dabs[0]  <= dabs;
            r_magok[0] <= (dabs >= W'(r_tol));
            for (int j = 0; j < 3; j++) begin
                r_rem[0][j] <= nwide[j][PW-1:W];
                r_lo[0][j]  <= nwide[j][W-1:0];
                r_ovf[0][j] <= (nwide[j][PW-1:W] >= dabs);
                r_neg[0][j] <= r_dot[j+1][W-1] ^ r_dot[0][W-1];
                r_nz[0][j]  <= |r_dot[j+1];
            end
        end
    end

    for (genvar k = 0; k < NDV; k++) begin : g_div
        logic [W:0] trial [3];
        logic [W:0] diff  [3];

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                trial[j] = {r_rem[k][j], r_lo[k][j][W-1]};
                diff[j]  = trial[j] - {1'b0, r_dabs[k]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dabs[k+1]  <= r_dabs[k];
                r_magok[k+1] <= r_magok[k];
                for (int j = 0; j < 3; j++) begin
                    r_rem[k+1][j] <= diff[j][W] ? trial[j][W-1:0] : diff[j][W-1:0];
                    r_lo[k+1][j]  <= {r_lo[k][j][W-2:0], ~diff[j][W]};
                    r_ovf[k+1][j] <= r_ovf[k][j];
                    r_neg[k+1][j] <= r_neg[k][j];
                    r_nz[k+1][j]  <= r_nz[k][j];
                end
            end
        end
    end

    // ---------------- quotient saturation ----------------
    logic                r_fv;
    logic                r_fmag;
    logic signed [W-1:0] r_quo [3];
    logic signed [W-1:0] quo   [3];

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (!r_nz[NDV][j]) begin
                quo[j] = '0;
            end else if (r_ovf[NDV][j]) begin
                quo[j] = r_neg[NDV][j] ? SMIN : SMAX;
            end else if (!r_neg[NDV][j]) begin
                quo[j] = r_lo[NDV][j][W-1] ? SMAX : r_lo[NDV][j];
            end else begin
                quo[j] = (r_lo[NDV][j][W-1] && (|r_lo[NDV][j][W-2:0])) ?
                         SMIN : W'(-r_lo[NDV][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fmag <= r_magok[NDV];
            r_quo  <= quo;
        end
    end

    // ---------------- tolerance tests ----------------
    logic signed [CW-1:0] tol_c;
    logic signed [CW-1:0] lim_c;
    logic signed [CW-1:0] u_c;
    logic signed [CW-1:0] v_c;
    logic signed [CW-1:0] t_c;
    logic                 hit;

    always_comb begin
        tol_c = CW'(r_tol);
        lim_c = ONE + tol_c;
        u_c   = CW'(r_quo[0]);
        v_c   = CW'(r_quo[1]);
        t_c   = CW'(r_quo[2]);
        hit   = r_fmag && (u_c >= tol_c) && (u_c <= lim_c) && (v_c >= tol_c)
                && ((u_c + v_c) <= lim_c) && (t_c > -tol_c);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit <= hit;
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_fv      <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= NDV; k++) r_dvld[k] <= 1'b0;
        end else if (en) begin
            r_v1      <= i_tri.valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_dvld[0] <= r_v5;
            for (int k = 0; k < NDV; k++) r_dvld[k+1] <= r_dvld[k];
            r_fv      <= r_dvld[NDV];
            r_out_vld <= r_fv;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.data.hit = r_out_hit;

endmodule
`default_nettype wire

/* rtl/rti_checker.sv */
// Port-level checks for the ray/triangle intersection unit, with bind.
`default_nettype none
module rti_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_hit
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output side");

    a_fresh_pipe: assert property (@(posedge i_clk)
        !i_rst_n ##1 (i_rst_n && !(i_in_valid && i_in_ready)) |=> !i_out_valid)
        else $error("result without an item after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_hit)))
        else $error("stalled result changed");

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_tri.valid),
    .i_in_ready  (i_tri.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_hit   (o_res.data.hit)
);
`default_nettype wire
